### src/rce_pkg.sv
// Shared types and constants for the Roberts cross edge magnitude block.
// Used by the window front end, the square-root cells and the top level.
// No dependencies.
`default_nettype none

package rce_pkg;

    // Configuration register map
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = 11'd1024;

    // Default image limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Field widths
    localparam int PIX_W    = 8;
    localparam int POS_W    = 10;
    localparam int ROOT_W   = 8;           // one cell per root bit
    localparam int RAD_W    = 2 * ROOT_W;  // radicand below saturation
    localparam int REM_W    = ROOT_W + 1;
    localparam logic [PIX_W-1:0] MAG_SAT = 8'hFF;

    // Position and flags that travel alongside each request
    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             window_valid;
        logic             frame_last;
    } meta_t;

    // Working data handed from cell to cell
    typedef struct packed {
        meta_t             meta;
        logic              sat;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
        logic [RAD_W-1:0]  rad;
    } cell_t;

endpackage

`default_nettype wire

### src/rce_sqrt_cell.sv
// One cell of the square-root chain: settles one bit of the root.
// Depends on rce_pkg (cell_t).
`default_nettype none

module rce_sqrt_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          advance,
    input  wire logic          in_valid,
    input  rce_pkg::cell_t     in_data,
    output logic               out_valid,
    output rce_pkg::cell_t     out_data
);

    localparam int SH_W = rce_pkg::REM_W + 2;

    logic                   valid_reg;
    rce_pkg::cell_t         data_reg;
    rce_pkg::cell_t         data_next;
    logic [SH_W-1:0]        rem_sh;
    logic [SH_W-1:0]        trial;
    logic [SH_W-1:0]        diff;
    logic                   take;

    // Restoring digit step: bring down two radicand bits, try root*4+1
    always_comb begin
        rem_sh = {in_data.rem, in_data.rad[rce_pkg::RAD_W-1 -: 2]};
        trial  = {1'b0, in_data.root, 2'b01};
        diff   = rem_sh - trial;
        take   = (rem_sh >= trial);

        data_next      = in_data;
        data_next.root = {in_data.root[rce_pkg::ROOT_W-2:0], take};
        data_next.rem  = take ? diff[rce_pkg::REM_W-1:0] : rem_sh[rce_pkg::REM_W-1:0];
        data_next.rad  = {in_data.rad[rce_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### src/rce_window.sv
// Front end: frame registers, raster counters, line store, 2x2 window,
// gradients and sum of squares. Depends on rce_pkg.
`default_nettype none

module rce_window #(
    parameter int MAX_WIDTH  = rce_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rce_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [rce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rce_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          accept,
    input  wire logic                          advance,
    input  wire logic [rce_pkg::PIX_W-1:0]     pixel,
    output logic                               out_valid,
    output rce_pkg::cell_t                     out_data
);

    localparam int COL_W  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMPC_W = (rce_pkg::CFG_W > COL_W + 1) ? rce_pkg::CFG_W : COL_W + 1;
    localparam int CMPR_W = (rce_pkg::CFG_W > ROW_W + 1) ? rce_pkg::CFG_W : ROW_W + 1;
    localparam int PW     = rce_pkg::PIX_W;
    localparam int POS_W  = rce_pkg::POS_W;

    logic [rce_pkg::CFG_W-1:0] width_cfg_reg;
    logic [rce_pkg::CFG_W-1:0] height_cfg_reg;
    logic [COL_W-1:0]          col_count_reg;
    logic [COL_W-1:0]          col_count_next;
    logic [ROW_W-1:0]          row_count_reg;
    logic [ROW_W-1:0]          row_count_next;
    logic [PW-1:0]             left_reg;
    logic [PW-1:0]             upleft_reg;
    logic [PW-1:0]             above_reg;
    logic [PW-1:0]             line_mem [MAX_WIDTH];
    logic [COL_W-1:0]          rd_addr;

    logic [CMPC_W-1:0]         w_ext;
    logic [CMPR_W-1:0]         h_ext;
    logic [COL_W-1:0]          last_col;
    logic [ROW_W-1:0]          last_row;
    logic                      col_wrap;
    logic                      row_wrap;
    logic                      win_ok;
    logic [COL_W-1:0]          col_m1;
    logic [ROW_W-1:0]          row_m1;
    logic [COL_W+POS_W-1:0]    col_ext;
    logic [ROW_W+POS_W-1:0]    row_ext;

    logic signed [PW:0]        gx_next;
    logic signed [PW:0]        gy_next;
    rce_pkg::meta_t            meta_next;

    logic                      a_valid_reg;
    logic signed [PW:0]        gx_reg;
    logic signed [PW:0]        gy_reg;
    rce_pkg::meta_t            a_meta_reg;

    logic signed [2*PW+1:0]    sq_x;
    logic signed [2*PW+1:0]    sq_y;
    logic [rce_pkg::RAD_W:0]   sum;
    logic                      b_valid_reg;
    rce_pkg::cell_t            b_data_reg;
    rce_pkg::cell_t            b_data_next;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= rce_pkg::CFG_DIM_RESET;
            height_cfg_reg <= rce_pkg::CFG_DIM_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                rce_pkg::REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_data;
                rce_pkg::REG_FRAME_HEIGHT: height_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp frame size to [2, MAX] and form the last column and row
    always_comb begin
        w_ext = CMPC_W'(width_cfg_reg);
        h_ext = CMPR_W'(height_cfg_reg);
        if (width_cfg_reg < rce_pkg::CFG_W'(2)) begin
            last_col = COL_W'(1);
        end else if (w_ext > CMPC_W'(MAX_WIDTH)) begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_W'(w_ext - CMPC_W'(1));
        end
        if (height_cfg_reg < rce_pkg::CFG_W'(2)) begin
            last_row = ROW_W'(1);
        end else if (h_ext > CMPR_W'(MAX_HEIGHT)) begin
            last_row = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            last_row = ROW_W'(h_ext - CMPR_W'(1));
        end
    end

    // Raster position; a counter at or past the end wraps
    always_comb begin
        col_wrap = (col_count_reg >= last_col);
        row_wrap = (row_count_reg >= last_row);
        if (col_wrap) begin
            col_count_next = '0;
            row_count_next = row_wrap ? '0 : row_count_reg + ROW_W'(1);
        end else begin
            col_count_next = col_count_reg + COL_W'(1);
            row_count_next = row_count_reg;
        end
        rd_addr = accept ? col_count_next : col_count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            left_reg      <= '0;
            upleft_reg    <= '0;
        end else if (accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            left_reg      <= pixel;
            upleft_reg    <= above_reg;
        end
    end

    // Line store: write the new pixel, prefetch the one above the next position
    always_ff @(posedge aclk) begin
        if (accept) begin
            line_mem[col_count_reg] <= pixel;
        end
        above_reg <= line_mem[rd_addr];
    end

    // Gradients and output position for the window ending at this pixel
    always_comb begin
        win_ok  = (col_count_reg != '0) && (row_count_reg != '0);
        col_m1  = col_count_reg - COL_W'(1);
        row_m1  = row_count_reg - ROW_W'(1);
        col_ext = {{POS_W{1'b0}}, col_m1};
        row_ext = {{POS_W{1'b0}}, row_m1};
        gx_next = '0;
        gy_next = '0;
        meta_next = '0;
        if (win_ok) begin
            gx_next = $signed({1'b0, upleft_reg}) - $signed({1'b0, pixel});
            gy_next = $signed({1'b0, above_reg}) - $signed({1'b0, left_reg});
            meta_next.out_row      = row_ext[POS_W-1:0];
            meta_next.out_col      = col_ext[POS_W-1:0];
            meta_next.window_valid = 1'b1;
        end
        meta_next.frame_last = col_wrap && row_wrap;
    end

    // Stage A: gradients
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gx_reg     <= gx_next;
            gy_reg     <= gy_next;
            a_meta_reg <= meta_next;
        end
    end

    // Stage B: sum of squares, seeded for the root chain
    always_comb begin
        sq_x = gx_reg * gx_reg;
        sq_y = gy_reg * gy_reg;
        sum  = {1'b0, sq_x[rce_pkg::RAD_W-1:0]} + {1'b0, sq_y[rce_pkg::RAD_W-1:0]};
        b_data_next.meta = a_meta_reg;
        b_data_next.sat  = sum[rce_pkg::RAD_W];
        b_data_next.root = '0;
        b_data_next.rem  = '0;
        b_data_next.rad  = sum[rce_pkg::RAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

### src/roberts_cross_edge_magnitude.sv
// Roberts cross edge magnitude over a raster pixel stream.
// Each accepted pixel reaches m_* through the gradient, square, eight root-cell and
// output registers; one pixel per cycle sustained while m_ready holds. A stalled
// result holds the whole pipeline. Synchronous active-low reset clears counters,
// the left and upper-left window pixels and valid flags, holds s_ready low and
// returns frame size to 1024; the line store is not cleared.
`default_nettype none

module roberts_cross_edge_magnitude #(
    parameter int MAX_WIDTH  = rce_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rce_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [rce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rce_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rce_pkg::PIX_W-1:0]     s_pixel,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [rce_pkg::PIX_W-1:0]          m_magnitude,
    output logic [rce_pkg::POS_W-1:0]          m_out_row,
    output logic [rce_pkg::POS_W-1:0]          m_out_col,
    output logic                               m_window_valid,
    output logic                               m_frame_last
);

    localparam int NCELLS = rce_pkg::ROOT_W;

    logic                       advance;
    logic                       accept;
    logic [NCELLS:0]            chain_valid;
    rce_pkg::cell_t             chain_data [NCELLS+1];
    rce_pkg::cell_t             last_data;

    logic                       m_valid_reg;
    logic [rce_pkg::PIX_W-1:0]  mag_reg;
    rce_pkg::meta_t             meta_reg;

    // Pipeline moves whenever the output register is free or being emptied;
    // no request is taken while reset is held
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance && aresetn;
    assign accept  = s_valid && s_ready;

    rce_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .advance   (advance),
        .pixel     (s_pixel),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // Square-root chain, one cell per root bit
    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        rce_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign last_data = chain_data[NCELLS];

    // Output register with saturation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= chain_valid[NCELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mag_reg  <= last_data.sat ? rce_pkg::MAG_SAT : last_data.root;
            meta_reg <= last_data.meta;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_magnitude    = mag_reg;
    assign m_out_row      = meta_reg.out_row;
    assign m_out_col      = meta_reg.out_col;
    assign m_window_valid = meta_reg.window_valid;
    assign m_frame_last   = meta_reg.frame_last;

endmodule

`default_nettype wire

### src/rce_checker.sv
// Port-level checks for the Roberts cross edge magnitude block, and the bind
// that attaches them to the top level. Depends on rce_pkg.
`default_nettype none

module rce_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [rce_pkg::PIX_W-1:0]     m_magnitude,
    input wire logic [rce_pkg::POS_W-1:0]     m_out_row,
    input wire logic [rce_pkg::POS_W-1:0]     m_out_col,
    input wire logic                          m_window_valid,
    input wire logic                          m_frame_last
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_magnitude) && $stable(m_out_row)
            && $stable(m_out_col) && $stable(m_window_valid) && $stable(m_frame_last))
        else $error("result changed while stalled");

    // No request is taken while the output waits
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken during output stall");

    // Results without a full window are zero
    a_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_valid |->
            m_magnitude == '0 && m_out_row == '0 && m_out_col == '0)
        else $error("edge result carries data");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind roberts_cross_edge_magnitude rce_checker u_rce_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_magnitude    (m_magnitude),
    .m_out_row      (m_out_row),
    .m_out_col      (m_out_col),
    .m_window_valid (m_window_valid),
    .m_frame_last   (m_frame_last)
);

`default_nettype wire
